// ===== hdl/cooperative_task_scheduler_assert.svh =====
// Assertion macros for the cooperative task scheduler checker.
`ifndef COOPERATIVE_TASK_SCHEDULER_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CTS_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cts check failed: same-cycle rule");

// Next-cycle implication, disabled in reset.
`define CTS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cts check failed: next-cycle rule");

`endif

// ===== hdl/cts_pkg.sv =====
// Shared types and constants of the cooperative task scheduler.
package cts_pkg;

  localparam int MAX_TASKS    = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);
  localparam int RCNT_W       = $clog2(RESULT_LIMIT + 1);

  localparam int ACTION_W     = 2;
  localparam int HANDLE_W     = 16;
  localparam int DELAY_W      = 32;
  localparam int PENDING_W    = 8;
  localparam int SLOT_FIELD_W = 3;

  localparam logic [PENDING_W-1:0] PEND_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [DELAY_W-1:0]   delay;
    logic [DELAY_W-1:0]   period;
    logic [PENDING_W-1:0] pending;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Result of one slot update: new contents, write strobe, dispatch hit.
  typedef struct packed {
    slot_entry_t ent;
    logic        wr;
    logic        emit;
  } slot_upd_t;

endpackage

// ===== hdl/cts_ram.sv =====
// Generic single-port-write, registered-read RAM.
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/cts_slot_alu.sv =====
// Per-slot update: tick countdown/reload or dispatch consume.
module cts_slot_alu (
  input  cts_pkg::slot_entry_t ent,
  input  logic                 is_dispatch,
  input  logic                 room,
  output cts_pkg::slot_upd_t   upd
);
  import cts_pkg::*;

  always_comb begin
    upd      = '0;
    upd.ent  = ent;
    if (is_dispatch) begin
      if (ent.pending != '0 && room) begin
        upd.ent.pending = ent.pending - PENDING_W'(1);
        upd.wr          = 1'b1;
        upd.emit        = 1'b1;
      end
    end else if (ent.handle != '0) begin
      upd.wr = 1'b1;
      if (ent.delay != '0) begin
        upd.ent.delay = ent.delay - DELAY_W'(1);
      end else begin
        if (ent.pending != PEND_MAX) begin
          upd.ent.pending = ent.pending + PENDING_W'(1);
        end
        if (ent.period != '0) begin
          upd.ent.delay = ent.period;
        end
      end
    end
  end

endmodule

// ===== hdl/cooperative_task_scheduler.sv =====
// Top level of the cooperative task scheduler: slot table walker and result port.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_valid / in_ready    | action, task_handle, start_delay, period, slot
//  out_    | out | out_valid / out_ready  | slot_number, ready_handle, success, last
//
// Delete stays in ST_IDLE; add goes on to ST_FIN; tick walks the used slots and returns
//   to idle; dispatch walks them and then goes through ST_FIN. The walk reads one slot
//   per cycle from the slot RAM, unless stalled, with the write-back overlapped.
// Reset: synchronous; per-slot valid bits clear the table at once, no clearing pass.
// Stalls: a dispatch walk pauses while the output register holds an untaken
//   transaction and a held hit must move out; the final add or dispatch transaction
//   waits for the output register; input is taken only between walks.
module cooperative_task_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cts_pkg::ACTION_W-1:0]      in_action,
  input  logic [cts_pkg::HANDLE_W-1:0]      in_task_handle,
  input  logic [cts_pkg::DELAY_W-1:0]       in_start_delay,
  input  logic [cts_pkg::DELAY_W-1:0]       in_period,
  input  logic [cts_pkg::SLOT_FIELD_W-1:0]  in_slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cts_pkg::SLOT_FIELD_W-1:0]  out_slot_number,
  output logic [cts_pkg::HANDLE_W-1:0]      out_ready_handle,
  output logic                              out_success,
  output logic                              out_last
);
  import cts_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;

  state_t               state_r, state_nxt;
  logic                 is_disp_r, is_disp_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]     slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 mod_vld_r, mod_vld_nxt;
  logic [IDX_W-1:0]     mod_idx_r, mod_idx_nxt;
  logic [RCNT_W-1:0]    emitted_r, emitted_nxt;
  // Held result: dispatch emits one behind so the final one can carry last.
  logic                 hold_vld_r, hold_vld_nxt;
  logic [IDX_W-1:0]     hold_slot_r, hold_slot_nxt;
  logic [HANDLE_W-1:0]  hold_handle_r, hold_handle_nxt;
  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [SLOT_FIELD_W-1:0] out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0]     out_handle_r, out_handle_nxt;
  logic                    out_success_r, out_success_nxt;
  logic                    out_last_r, out_last_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_entry_t      ram_wdata, ram_rdata, cur_ent;
  slot_upd_t        upd;

  logic out_free, rd_more, room, stall, adv, in_fire;

  cts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_TASKS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Entries not yet written (or deleted) read as all zero.
  assign cur_ent = valid_r[mod_idx_r] ? ram_rdata : '0;
  assign room    = emitted_r < RCNT_W'(RESULT_LIMIT);

  cts_slot_alu u_slot_alu (
    .ent        (cur_ent),
    .is_dispatch(is_disp_r),
    .room       (room),
    .upd        (upd)
  );

  assign out_free = !out_valid_r || out_ready;
  assign rd_more  = rd_idx_r < slots_used_r;
  assign stall    = (state_r == ST_WALK) && mod_vld_r && upd.emit && hold_vld_r && !out_free;
  assign adv      = !stall;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign ram_re    = (state_r == ST_WALK) && adv && rd_more;
  assign ram_raddr = rd_idx_r[IDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    is_disp_nxt     = is_disp_r;
    valid_nxt       = valid_r;
    slots_used_nxt  = slots_used_r;
    rd_idx_nxt      = rd_idx_r;
    mod_vld_nxt     = mod_vld_r;
    mod_idx_nxt     = mod_idx_r;
    emitted_nxt     = emitted_r;
    hold_vld_nxt    = hold_vld_r;
    hold_slot_nxt   = hold_slot_r;
    hold_handle_nxt = hold_handle_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_slot_nxt    = out_slot_r;
    out_handle_nxt  = out_handle_r;
    out_success_nxt = out_success_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = mod_idx_r;
    ram_wdata       = upd.ent;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (action_t'(in_action))
            ACT_TICK, ACT_DISPATCH: begin
              state_nxt       = ST_WALK;
              is_disp_nxt     = (action_t'(in_action) == ACT_DISPATCH);
              rd_idx_nxt      = '0;
              mod_vld_nxt     = 1'b0;
              emitted_nxt     = '0;
              hold_vld_nxt    = 1'b0;
              hold_slot_nxt   = '0;
              hold_handle_nxt = '0;
            end
            ACT_ADD: begin
              state_nxt       = ST_FIN;
              hold_handle_nxt = '0;
              if (slots_used_r < CNT_W'(MAX_TASKS)) begin
                ram_we                          = 1'b1;
                ram_waddr                       = slots_used_r[IDX_W-1:0];
                ram_wdata.handle                = in_task_handle;
                ram_wdata.delay                 = in_start_delay;
                ram_wdata.period                = in_period;
                ram_wdata.pending               = '0;
                valid_nxt[slots_used_r[IDX_W-1:0]] = 1'b1;
                slots_used_nxt                  = slots_used_r + CNT_W'(1);
                hold_vld_nxt                    = 1'b1;
                hold_slot_nxt                   = slots_used_r[IDX_W-1:0];
              end else begin
                hold_vld_nxt  = 1'b0;
                hold_slot_nxt = '0;
              end
            end
            ACT_DELETE: begin
              // Clearing the valid bit makes the slot read as zero.
              if (32'(in_slot) < 32'(MAX_TASKS)) begin
                valid_nxt[IDX_W'(in_slot)] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (adv) begin
          if (mod_vld_r && upd.wr) begin
            ram_we = 1'b1;
          end
          if (mod_vld_r && upd.emit) begin
            if (hold_vld_r) begin
              out_valid_nxt   = 1'b1;
              out_slot_nxt    = SLOT_FIELD_W'(hold_slot_r);
              out_handle_nxt  = hold_handle_r;
              out_success_nxt = 1'b1;
              out_last_nxt    = 1'b0;
            end
            hold_vld_nxt    = 1'b1;
            hold_slot_nxt   = mod_idx_r;
            hold_handle_nxt = cur_ent.handle;
            emitted_nxt     = emitted_r + RCNT_W'(1);
          end
          mod_vld_nxt = rd_more;
          mod_idx_nxt = rd_idx_r[IDX_W-1:0];
          if (rd_more) begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
          end
          if (!mod_vld_r && !rd_more) begin
            state_nxt = is_disp_r ? ST_FIN : ST_IDLE;
          end
        end
      end

      ST_FIN: begin
        // Final transaction: add result, last dispatch hit, or "nothing ready".
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = SLOT_FIELD_W'(hold_slot_r);
          out_handle_nxt  = hold_handle_r;
          out_success_nxt = hold_vld_r;
          out_last_nxt    = 1'b1;
          hold_vld_nxt    = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      is_disp_r    <= 1'b0;
      valid_r      <= '0;
      slots_used_r <= '0;
      rd_idx_r     <= '0;
      mod_vld_r    <= 1'b0;
      emitted_r    <= '0;
      hold_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      is_disp_r     <= is_disp_nxt;
      valid_r       <= valid_nxt;
      slots_used_r  <= slots_used_nxt;
      rd_idx_r      <= rd_idx_nxt;
      mod_vld_r     <= mod_vld_nxt;
      mod_idx_r     <= mod_idx_nxt;
      emitted_r     <= emitted_nxt;
      hold_vld_r    <= hold_vld_nxt;
      hold_slot_r   <= hold_slot_nxt;
      hold_handle_r <= hold_handle_nxt;
      out_valid_r   <= out_valid_nxt;
      out_slot_r    <= out_slot_nxt;
      out_handle_r  <= out_handle_nxt;
      out_success_r <= out_success_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_number  = out_slot_r;
  assign out_ready_handle = out_handle_r;
  assign out_success      = out_success_r;
  assign out_last         = out_last_r;

endmodule

// ===== hdl/cts_checker.sv =====
// Port-level checker for the cooperative task scheduler, bound to the top level.
`include "cooperative_task_scheduler_assert.svh"

module cts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cts_pkg::SLOT_FIELD_W-1:0]  out_slot_number,
  input logic [cts_pkg::HANDLE_W-1:0]      out_ready_handle,
  input logic                              out_success,
  input logic                              out_last
);
  import cts_pkg::*;

  logic [SLOT_FIELD_W+HANDLE_W+1:0] out_bundle;
  logic                             out_stalled;
  logic                             fail_shape;

  assign out_bundle  = {out_slot_number, out_ready_handle, out_success, out_last};
  assign out_stalled = out_valid && !out_ready;
  assign fail_shape  = out_last && out_slot_number == '0 && out_ready_handle == '0;

  // Stalled result transaction stays up, unchanged.
  `CTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, out_valid && $stable(out_bundle))
  // No result right after reset.
  `CTS_ASSERT_NOW(a_out_reset, clk, rst_n, $past(!rst_n), !out_valid)
  // A failed add or empty dispatch is the only, all-zero result.
  `CTS_ASSERT_NOW(a_fail_form, clk, rst_n, out_valid && !out_success, fail_shape)
  // A nonzero handle only comes with a dispatch hit.
  `CTS_ASSERT_NOW(a_handle_ok, clk, rst_n, out_valid && out_ready_handle != '0, out_success)

endmodule

bind cooperative_task_scheduler cts_checker u_cts_checker (.*);

// ===== verif/cooperative_task_scheduler_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cooperative task scheduler: directed and random traffic.
module cooperative_task_scheduler_test;
  import cts_pkg::*;

  // Run length and pressure knobs.
  localparam int CYCLE_LIMIT = 500000;  // worst legal run is well under this
  localparam int LONG_HOLD   = 250;     // receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES = 40;      // drain time after the last expected result
  localparam int BUILD_TICKS = 6;       // ticks that pile up runs on an every-tick slot
  localparam int RAND_ITEMS  = 70;
  localparam int CALM_ITEMS  = 25;      // trailing random transactions with no idling

  // One request to the scheduler, plus sender pacing flags.
  typedef struct {
    action_t                 action;
    logic [HANDLE_W-1:0]     handle;
    logic [DELAY_W-1:0]      delay;
    logic [DELAY_W-1:0]      period;
    logic [SLOT_FIELD_W-1:0] slot;
    bit                      wait_idle;  // hold this one back until all results are in
    bit                      calm;       // from here on, no idling on either side
  } sched_req_t;

  // One result transaction as seen on the out_ channel.
  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot_number;
    logic [HANDLE_W-1:0]     ready_handle;
    logic                    success;
    logic                    is_last;
  } sched_result_t;

  // Rejected add, or dispatch with nothing ready.
  localparam sched_result_t REFUSED = '{slot_number: '0, ready_handle: '0,
                                        success: 1'b0, is_last: 1'b1};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ACTION_W-1:0]     in_action = ACT_TICK;
  logic [HANDLE_W-1:0]     in_task_handle = '0;
  logic [DELAY_W-1:0]      in_start_delay = '0;
  logic [DELAY_W-1:0]      in_period = '0;
  logic [SLOT_FIELD_W-1:0] in_slot = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SLOT_FIELD_W-1:0] out_slot_number;
  logic [HANDLE_W-1:0]     out_ready_handle;
  logic                    out_success;
  logic                    out_last;

  cooperative_task_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_task_handle   (in_task_handle),
    .in_start_delay   (in_start_delay),
    .in_period        (in_period),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_number  (out_slot_number),
    .out_ready_handle (out_ready_handle),
    .out_success      (out_success),
    .out_last         (out_last)
  );

  // Scheduler shadow state, advanced once per accepted request.
  logic [HANDLE_W-1:0]  tbl_handle [MAX_TASKS];
  logic [DELAY_W-1:0]   tbl_delay  [MAX_TASKS];
  logic [DELAY_W-1:0]   tbl_period [MAX_TASKS];
  logic [PENDING_W-1:0] tbl_runs   [MAX_TASKS];
  int                   slots_taken;

  sched_req_t    request_q[$];    // requests not yet offered
  sched_result_t owed_results[$]; // results the block still owes us

  // Bookkeeping. Cross-process counters use NBAs, but results_predicted does not.
  logic [31:0] cycle_count = '0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          results_predicted = 0;
  int          mismatches = 0;
  int          total_items = 0;
  int          hold_at = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void clear_entry(int idx);
    tbl_handle[idx] = '0;
    tbl_delay[idx]  = '0;
    tbl_period[idx] = '0;
    tbl_runs[idx]   = '0;
  endfunction

  // Advance the shadow table by one request and queue the results it owes.
  function automatic void apply_request(action_t act, logic [HANDLE_W-1:0] h,
                                        logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] p,
                                        logic [SLOT_FIELD_W-1:0] s);
    sched_result_t batch[$];
    int i;
    case (act)
      ACT_TICK: begin
        // Zero-handle slots are dead weight: they never count or fire.
        for (i = 0; i < slots_taken; i++) begin
          if (tbl_handle[i] != '0) begin
            if (tbl_delay[i] != '0) begin
              tbl_delay[i]--;
            end else begin
              if (tbl_runs[i] != PEND_MAX) tbl_runs[i]++;
              if (tbl_period[i] != '0) tbl_delay[i] = tbl_period[i];
            end
          end
        end
      end
      ACT_ADD: begin
        // Slots are handed out once, in order; deletes never free one.
        if (slots_taken < MAX_TASKS) begin
          tbl_handle[slots_taken] = h;
          tbl_delay[slots_taken]  = d;
          tbl_period[slots_taken] = p;
          tbl_runs[slots_taken]   = '0;
          batch.push_back('{slot_number: SLOT_FIELD_W'(slots_taken), ready_handle: '0,
                            success: 1'b1, is_last: 1'b1});
          slots_taken++;
        end else begin
          batch.push_back(REFUSED);
        end
      end
      ACT_DELETE: begin
        if (int'(s) < MAX_TASKS) clear_entry(int'(s));
      end
      ACT_DISPATCH: begin
        for (i = 0; i < slots_taken && batch.size() < RESULT_LIMIT; i++) begin
          if (tbl_runs[i] != '0) begin
            tbl_runs[i]--;
            batch.push_back('{slot_number: SLOT_FIELD_W'(i), ready_handle: tbl_handle[i],
                              success: 1'b1, is_last: 1'b0});
          end
        end
        if (batch.size() == 0) batch.push_back(REFUSED);
        else batch[batch.size()-1].is_last = 1'b1;
      end
      default: begin
      end
    endcase
    foreach (batch[j]) owed_results.push_back(batch[j]);
    results_predicted += batch.size();
  endfunction

  function automatic void queue_req(action_t a, logic [HANDLE_W-1:0] h,
                                    logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] p,
                                    logic [SLOT_FIELD_W-1:0] s,
                                    bit wait_idle = 1'b0, bit calm_req = 1'b0);
    sched_req_t r;
    r.action    = a;
    r.handle    = h;
    r.delay     = d;
    r.period    = p;
    r.slot      = s;
    r.wait_idle = wait_idle;
    r.calm      = calm_req;
    request_q.push_back(r);
  endfunction

  // Fields the action does not use still carry random bits.
  function automatic void noise_req(action_t a, bit wait_idle = 1'b0, bit calm_req = 1'b0);
    queue_req(a, HANDLE_W'($urandom), $urandom, $urandom,
              SLOT_FIELD_W'($urandom_range(0, 7)), wait_idle, calm_req);
  endfunction

  // Driver: offers the next queued request, holds it until taken, predicts at acceptance.
  always @(posedge clk) begin
    sched_req_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(action_t'(in_action), in_task_handle, in_start_delay, in_period,
                      in_slot);
        items_taken <= items_taken + 1;
      end
      if (in_valid && !in_ready) begin
        // transaction still waiting; payload stays put
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].wait_idle && results_seen < results_predicted)) begin
        in_valid <= 1'b0;
      end else if (!calm && hold_left == 0 && cycle_count[8:7] != 2'b01 &&
                   $urandom_range(0, 7) == 0) begin
        // idle burst starting with this one; none while the receiver
        // is holding off, so the input side backs up
        gap_left <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else begin
        nx = request_q.pop_front();
        in_valid       <= 1'b1;
        in_action      <= nx.action;
        in_task_handle <= nx.handle;
        in_start_delay <= nx.delay;
        in_period      <= nx.period;
        in_slot        <= nx.slot;
        if (nx.calm) calm <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest owed one, drives out_ready.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{slot_number: out_slot_number, ready_handle: out_ready_handle,
                success: out_success, is_last: out_last};
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result: slot %0d handle %h success %b last %b",
                                 got.slot_number, got.ready_handle, got.success,
                                 got.is_last));
        end else begin
          want = owed_results.pop_front();
          if (got !== want)
            log_mismatch($sformatf({"expected slot %0d handle %h success %b last %b, ",
                                    "actual slot %0d handle %h success %b last %b"},
                                   want.slot_number, want.ready_handle, want.success,
                                   want.is_last, got.slot_number, got.ready_handle,
                                   got.success, got.is_last));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && items_taken >= hold_at) begin
        // one long hold-off: a dispatch walk stalls and the input stops taking
        hold_left <= LONG_HOLD - 1;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (cycle_count[7:6] != 2'b11 && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 18);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cooperative_task_scheduler regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    int pick;
    bit calm_item;
    for (k = 0; k < MAX_TASKS; k++) clear_entry(k);
    slots_taken = 0;

    // Directed: empty table, extreme handles and delays, zero handle, period zero,
    // delete of a slot not yet handed out, delete of a live slot.
    noise_req(ACT_DISPATCH);                                    // nothing pending
    noise_req(ACT_TICK);                                        // no slots in use
    queue_req(ACT_ADD, 16'hFFFF, 32'd0, 32'd0, 3'd5);           // slot 0, fires every tick
    queue_req(ACT_ADD, 16'h0000, 32'd0, 32'd0, 3'd2);           // slot 1, zero handle
    queue_req(ACT_ADD, 16'h0001, 32'd2, 32'd3, 3'd7);           // slot 2, periodic
    queue_req(ACT_DELETE, HANDLE_W'($urandom), $urandom, $urandom, 3'd7);  // not handed out
    for (k = 0; k < 4; k++) noise_req(ACT_TICK);
    noise_req(ACT_DISPATCH);
    noise_req(ACT_DISPATCH);
    queue_req(ACT_DELETE, HANDLE_W'($urandom), $urandom, $urandom, 3'd0);
    noise_req(ACT_TICK);
    noise_req(ACT_DISPATCH);
    queue_req(ACT_ADD, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);  // slot 3
    noise_req(ACT_TICK);
    noise_req(ACT_DISPATCH);

    // Pending runs pile up on an every-tick slot, started from an idle block.
    queue_req(ACT_ADD, 16'h7E7E, 32'd0, 32'd0, 3'd3, 1'b1);     // slot 4
    for (k = 0; k < BUILD_TICKS; k++) noise_req(ACT_TICK);
    noise_req(ACT_DISPATCH);
    noise_req(ACT_DISPATCH);

    hold_at = request_q.size() + 20;

    // Random: mostly ticks and dispatches so live slots keep firing; adds fill the
    // table and then get refused; deletes are rare since a cleared slot stays dead.
    for (k = 0; k < RAND_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      calm_item = (k >= RAND_ITEMS - CALM_ITEMS);
      if (pick < 48) begin
        noise_req(ACT_TICK, k == 50, calm_item);
      end else if (pick < 80) begin
        noise_req(ACT_DISPATCH, k == 50, calm_item);
      end else if (pick < 94) begin
        queue_req(ACT_ADD,
                  ($urandom_range(0, 7) == 0) ? 16'h0000 : HANDLE_W'($urandom),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5),
                  SLOT_FIELD_W'($urandom_range(0, 7)), k == 50, calm_item);
      end else begin
        noise_req(ACT_DELETE, k == 50, calm_item);
      end
    end
    // At most three slots were left, so at least one of these is refused.
    for (k = 0; k < 4; k++)
      queue_req(ACT_ADD, HANDLE_W'($urandom), $urandom_range(0, 3), $urandom_range(0, 3),
                SLOT_FIELD_W'($urandom_range(0, 7)), 1'b0, 1'b1);
    noise_req(ACT_TICK, 1'b0, 1'b1);
    noise_req(ACT_DISPATCH, 1'b0, 1'b1);
    total_items = request_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge, clear of the clocked processes.
    do @(negedge clk);
    while (items_taken < total_items || results_seen < results_predicted);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (owed_results.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived, oldest slot %0d handle %h",
                             owed_results.size(), owed_results[0].slot_number,
                             owed_results[0].ready_handle));

    if (mismatches == 0) begin
      $display("cooperative_task_scheduler regression: pass");
    end else begin
      $display("cooperative_task_scheduler regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cts_pkg.sv
hdl/cts_ram.sv
hdl/cts_slot_alu.sv
hdl/cooperative_task_scheduler.sv
hdl/cts_checker.sv
verif/cooperative_task_scheduler_test.sv
